>>> rtl/lcbp_pkg.sv
// Shared types and constants for the layer compositor bitplane packer.
`timescale 1ns / 1ps
`default_nettype none
package lcbp_pkg;

	localparam int INPUT_LAYERS  = 4;
	localparam int ROWS_PER_BYTE = 8;
	localparam int COLOR_W       = 3;
	localparam int ADDR_W        = 13;
	localparam int BYTE_W        = 8;
	localparam int BIT_W         = 3;

	localparam int FRAME_WIDTH_W   = 9;
	localparam int HEIGHT_GROUPS_W = 4;
	localparam int MASK_W          = 4;

	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT_GROUPS = 2'd1;
	localparam logic [1:0] REG_VISIBLE_MASK  = 2'd2;

	localparam logic [FRAME_WIDTH_W-1:0]   FRAME_WIDTH_RST   = 9'd256;
	localparam logic [HEIGHT_GROUPS_W-1:0] HEIGHT_GROUPS_RST = 4'd2;
	localparam logic [MASK_W-1:0]          VISIBLE_MASK_RST  = 4'd15;

	localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		color_t layer0_color;
		color_t layer1_color;
		color_t layer2_color;
		color_t layer3_color;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red_byte;
		logic [BYTE_W-1:0] green_byte;
		logic [BYTE_W-1:0] blue_byte;
		logic [ADDR_W-1:0] red_addr;
		logic [ADDR_W-1:0] green_addr;
		logic [ADDR_W-1:0] blue_addr;
		logic              frame_last;
	} out_item_t;

	typedef struct packed {
		logic hit;
		color_t color;
	} lane_res_t;

endpackage
`default_nettype wire

>>> rtl/layer_compositor_bitplane_packer_core.sv
// Layer compositor and RGB bitplane packer top level with its register port.
// Usage:
//   Input channel (in_valid/in_ready/in_data): one pixel per transfer, columns in
//   order, rows top to bottom within a column, four 3-bit layer colours each.
//   Output channel (out_valid/out_ready/out_data): one transfer per group of
//   eight rows: red, green and blue plane bytes, their buffer addresses and a
//   frame-end flag on the last group of the last column.
//   Register port: frame_width at 0x0, height_groups at 0x4, visible_mask at 0x8;
//   write only while no pixel is in flight.
//   Throughput: one pixel per cycle while in_ready is high; four colour lanes
//   and a priority merge work on each pixel in the cycle it is accepted.
//   Path: a closing pixel loads the result stage, then the output register.
//   Stall: a result stage and the output register hold results while out_ready
//   is low; pixels that close no group are still taken, and the pixel that
//   closes a group waits only while both are full.
//   Reset: registers return to width 256, two groups, all layers visible; the
//   row and column counters and plane bytes clear, no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module layer_compositor_bitplane_packer_core
	import lcbp_pkg::*;
#(
	parameter int LAYER_COUNT = 4,
	parameter int WIDTH_MAX   = 256,
	parameter int HEIGHT_MAX  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data
);

	localparam int LANES   = (LAYER_COUNT < INPUT_LAYERS) ? LAYER_COUNT : INPUT_LAYERS;
	localparam int GMAX    = HEIGHT_MAX / ROWS_PER_BYTE;
	localparam int COL_W   = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
	localparam int EW      = $clog2(WIDTH_MAX + 1);
	localparam int ROW_W   = $clog2(HEIGHT_MAX);
	localparam int GW      = $clog2(GMAX + 1);
	localparam int GROUP_W = (ROW_W > BIT_W) ? ROW_W - BIT_W : 1;

	logic [FRAME_WIDTH_W-1:0]   frame_width_q;
	logic [HEIGHT_GROUPS_W-1:0] height_groups_q;
	logic [MASK_W-1:0]          visible_mask_q;

	logic [EW-1:0] width_eff;
	logic [GW-1:0] groups_eff;
	logic          wr_en;
	color_t        colors [INPUT_LAYERS];
	lane_res_t     lane   [LANES];
	color_t        color;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FRAME_WIDTH_RST;
			height_groups_q <= HEIGHT_GROUPS_RST;
			visible_mask_q  <= VISIBLE_MASK_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_FRAME_WIDTH:   frame_width_q   <= pwdata[FRAME_WIDTH_W-1:0];
				REG_HEIGHT_GROUPS: height_groups_q <= pwdata[HEIGHT_GROUPS_W-1:0];
				REG_VISIBLE_MASK:  visible_mask_q  <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FRAME_WIDTH:   prdata = 32'(frame_width_q);
			REG_HEIGHT_GROUPS: prdata = 32'(height_groups_q);
			REG_VISIBLE_MASK:  prdata = 32'(visible_mask_q);
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		if (frame_width_q == '0) begin
			width_eff = EW'(1);
		end else if (32'(frame_width_q) > WIDTH_MAX) begin
			width_eff = EW'(WIDTH_MAX);
		end else begin
			width_eff = EW'(frame_width_q);
		end
		if (height_groups_q == '0) begin
			groups_eff = GW'(1);
		end else if (32'(height_groups_q) > GMAX) begin
			groups_eff = GW'(GMAX);
		end else begin
			groups_eff = GW'(height_groups_q);
		end
	end

	assign colors[0] = in_data.layer0_color;
	assign colors[1] = in_data.layer1_color;
	assign colors[2] = in_data.layer2_color;
	assign colors[3] = in_data.layer3_color;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		lcbp_lane u_lane (
			.color  (colors[i]),
			.enable (visible_mask_q[i]),
			.res    (lane[i])
		);
	end

	lcbp_merge #(
		.LANES (LANES)
	) u_merge (
		.lane  (lane),
		.color (color)
	);

	lcbp_pack #(
		.COL_W   (COL_W),
		.EW      (EW),
		.ROW_W   (ROW_W),
		.GW      (GW),
		.GROUP_W (GROUP_W)
	) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.width_eff  (width_eff),
		.groups_eff (groups_eff),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.color      (color),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

>>> rtl/lcbp_lane.sv
// One compositing lane: qualifies one layer's colour against its enable bit.
`timescale 1ns / 1ps
`default_nettype none
module lcbp_lane
	import lcbp_pkg::*;
(
	input  wire color_t    color,
	input  wire logic      enable,
	output lane_res_t      res
);

	always_comb begin
		res.hit   = enable && (color != '0);
		res.color = color;
	end

endmodule
`default_nettype wire

>>> rtl/lcbp_merge.sv
// Priority merge of lane results: the lowest-numbered hitting lane wins.
`timescale 1ns / 1ps
`default_nettype none
module lcbp_merge
	import lcbp_pkg::*;
#(
	parameter int LANES = 4
) (
	input  wire lane_res_t lane [LANES],
	output color_t         color
);

	always_comb begin
		color = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (lane[i].hit) begin
				color = lane[i].color;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/lcbp_pack.sv
// Row and column counters, bitplane shift bytes, result stage and output register.
`timescale 1ns / 1ps
`default_nettype none
module lcbp_pack
	import lcbp_pkg::*;
#(
	parameter int COL_W   = 8,
	parameter int EW      = 9,
	parameter int ROW_W   = 6,
	parameter int GW      = 4,
	parameter int GROUP_W = 3
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [EW-1:0]   width_eff,
	input  wire logic [GW-1:0]   groups_eff,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire color_t          color,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output out_item_t            out_data
);

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [BYTE_W-1:0]  red_q, green_q, blue_q;

	logic               valid_s1;
	logic [BYTE_W-1:0]  red_s1, green_s1, blue_s1;
	logic [COL_W-1:0]   col_s1;
	logic [GROUP_W-1:0] group_s1;
	logic               last_s1;

	logic               out_valid_q;
	out_item_t          out_q;

	logic [BIT_W-1:0]   bit_idx;
	logic               take, emit, row_wrap, col_wrap;
	logic               out_adv, s1_adv, s1_free;
	logic [BYTE_W-1:0]  red_nx, green_nx, blue_nx;
	logic [ADDR_W-1:0]  base, plane;

	assign bit_idx  = row_q[BIT_W-1:0];
	assign out_adv  = !out_valid_q || out_ready;
	assign s1_adv   = valid_s1 && out_adv;
	assign s1_free  = !valid_s1 || out_adv;
	assign in_ready = (bit_idx != LAST_BIT) || s1_free;
	assign take     = in_valid && in_ready;
	assign emit     = take && (bit_idx == LAST_BIT);
	assign row_wrap = (32'(row_q) + 1) >= (32'(groups_eff) * ROWS_PER_BYTE);
	assign col_wrap = (32'(col_q) + 1) >= 32'(width_eff);

	always_comb begin
		red_nx   = red_q;
		green_nx = green_q;
		blue_nx  = blue_q;
		red_nx[bit_idx]   = color[2];
		green_nx[bit_idx] = color[1];
		blue_nx[bit_idx]  = color[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (take) begin
			if (emit) begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end else begin
				red_q   <= red_nx;
				green_q <= green_nx;
				blue_q  <= blue_nx;
			end
			if (row_wrap) begin
				row_q <= '0;
				col_q <= col_wrap ? '0 : col_q + 1'b1;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			red_s1   <= red_nx;
			green_s1 <= green_nx;
			blue_s1  <= blue_nx;
			col_s1   <= col_q;
			group_s1 <= GROUP_W'(row_q >> BIT_W);
			last_s1  <= row_wrap && col_wrap;
		end
	end

	assign base  = ADDR_W'(32'(group_s1) + 32'(col_s1) * 32'(groups_eff));
	assign plane = ADDR_W'(32'(width_eff) * 32'(groups_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.red_byte   <= red_s1;
			out_q.green_byte <= green_s1;
			out_q.blue_byte  <= blue_s1;
			out_q.red_addr   <= base;
			out_q.green_addr <= base + plane;
			out_q.blue_addr  <= base + {plane[ADDR_W-2:0], 1'b0};
			out_q.frame_last <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
